### rtl/core/lbmbx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbmbx_pkg
// Shared types, codes and Q0.18 weights of the D2Q9 boundary extrapolation.
// ----------------------------------------------------------------------------
package lbmbx_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int COEF_BITS       = 18;
   localparam int NUM_SLOTS       = 9;

   // Node kinds.
   localparam logic [2:0] KIND_ON_WALL       = 3'd0;
   localparam logic [2:0] KIND_CONCAVE       = 3'd1;
   localparam logic [2:0] KIND_CONVEX        = 3'd2;
   localparam logic [2:0] KIND_WALL_SOLID    = 3'd3;
   localparam logic [2:0] KIND_CONCAVE_SOLID = 3'd4;
   localparam logic [2:0] KIND_CONVEX_SOLID  = 3'd5;

   // Stencil slots; corner normals use the diagonal slot codes.
   localparam logic [3:0] SLOT_C  = 4'd0;
   localparam logic [3:0] SLOT_E  = 4'd1;
   localparam logic [3:0] SLOT_N  = 4'd2;
   localparam logic [3:0] SLOT_W  = 4'd3;
   localparam logic [3:0] SLOT_S  = 4'd4;
   localparam logic [3:0] SLOT_NE = 4'd5;
   localparam logic [3:0] SLOT_NW = 4'd6;
   localparam logic [3:0] SLOT_SW = 4'd7;
   localparam logic [3:0] SLOT_SE = 4'd8;

   // Normalized distance weights, unsigned Q0.18.
   localparam logic [COEF_BITS-1:0] K_W1A = 18'd108584;
   localparam logic [COEF_BITS-1:0] K_W1B = 18'd76780;
   localparam logic [COEF_BITS-1:0] K_W2A = 18'd96835;
   localparam logic [COEF_BITS-1:0] K_W2B = 18'd68473;
   localparam logic [COEF_BITS-1:0] K_W3A = 18'd115741;
   localparam logic [COEF_BITS-1:0] K_W3B = 18'd73201;
   localparam logic [COEF_BITS-1:0] K_W4A = 18'd153560;
   localparam logic [COEF_BITS-1:0] K_W4B = 18'd108584;
   localparam logic [COEF_BITS-1:0] K_W5A = 18'd42825;
   localparam logic [COEF_BITS-1:0] K_W5B = 18'd30282;

   typedef logic [NUM_SLOTS-1:0][COEF_BITS-1:0] coef_vec_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] slot;
      logic       last;
   } ctl_type;

   // Straight slot on the other side of a straight slot.
   function automatic logic [3:0] opp_straight(input logic [3:0] s);
      return ((s + 4'd1) & 4'd3) + 4'd1;
   endfunction

   // Diagonal slot on the other side of a diagonal slot.
   function automatic logic [3:0] opp_diag(input logic [3:0] d);
      return ((d - 4'd3) & 4'd3) + 4'd5;
   endfunction

endpackage
`default_nettype wire

### rtl/core/lbmbx_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbmbx_seq
// Input register and result sequencer: holds one node and issues its zero, one
// or three weight sets, one per cycle while en is high.
// ----------------------------------------------------------------------------
module lbmbx_seq
   import lbmbx_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           req_vld,
   output logic                           req_rdy,
   input  logic [2:0]                     kind,
   input  logic [3:0]                     normal,
   input  logic [NUM_SLOTS*VALUE_WIDTH-1:0] vals,
   output ctl_type                        iss_ctl,
   output coef_vec_type                   iss_coef,
   output logic [NUM_SLOTS*VALUE_WIDTH-1:0] iss_vals
);

   logic                             hold_vld_ff, hold_vld_in;
   logic [1:0]                       idx_ff, idx_in;
   logic [2:0]                       kind_ff;
   logic [3:0]                       normal_ff;
   logic [NUM_SLOTS*VALUE_WIDTH-1:0] vals_ff;

   logic       straight, diag;
   logic [3:0] nx, ny, np;
   logic [1:0] cnt;
   logic       last_idx, issue, retire, accept;
   logic [3:0] slot;
   coef_vec_type k;

   assign straight = (normal_ff >= SLOT_E) && (normal_ff <= SLOT_S);
   assign diag     = (normal_ff >= SLOT_NE) && (normal_ff <= SLOT_SE);
   assign nx = (normal_ff == SLOT_NE || normal_ff == SLOT_SE) ? SLOT_E : SLOT_W;
   assign ny = (normal_ff == SLOT_NE || normal_ff == SLOT_NW) ? SLOT_N : SLOT_S;
   assign np = (normal_ff & 4'd3) + 4'd1;

   always_comb begin
      unique case (kind_ff) inside
         KIND_ON_WALL, KIND_WALL_SOLID:                cnt = straight ? 2'd1 : 2'd0;
         KIND_CONCAVE, KIND_CONVEX, KIND_CONVEX_SOLID: cnt = diag ? 2'd1 : 2'd0;
         KIND_CONCAVE_SOLID:                           cnt = diag ? 2'd3 : 2'd0;
         default:                                      cnt = 2'd0;
      endcase
   end

   // Weight set and target slot of result idx_ff of the held node.
   always_comb begin
      k    = '0;
      slot = SLOT_C;
      unique case (kind_ff)
         KIND_ON_WALL: begin
            if (straight) begin
               k[normal_ff]                          = K_W1A;
               k[normal_ff + 4'd4]                   = K_W1B;
               k[((normal_ff + 4'd2) & 4'd3) + 4'd5] = K_W1B;
            end
         end
         KIND_CONCAVE: begin
            if (diag) begin
               k[nx]        = K_W2A;
               k[ny]        = K_W2A;
               k[normal_ff] = K_W2B;
            end
         end
         KIND_CONVEX: begin
            if (diag) begin
               for (int i = 1; i <= 4; i++) k[i] = K_W5A;
               for (int i = 5; i <= 8; i++) k[i] = K_W5B;
               k[opp_diag(normal_ff)] = '0;
            end
         end
         KIND_WALL_SOLID: begin
            if (straight) begin
               k[SLOT_C]           = K_W1A;
               k[np]               = K_W1B;
               k[opp_straight(np)] = K_W1B;
               slot                = opp_straight(normal_ff);
            end
         end
         KIND_CONCAVE_SOLID: begin
            if (diag) begin
               if (idx_ff == 2'd0) begin
                  k[SLOT_C] = K_W4A;
                  k[ny]     = K_W4B;
                  slot      = opp_straight(nx);
               end else if (idx_ff == 2'd1) begin
                  k[SLOT_C] = K_W4A;
                  k[nx]     = K_W4B;
                  slot      = opp_straight(ny);
               end else begin
                  k[SLOT_C] = K_W3A;
                  k[nx]     = K_W3B;
                  k[ny]     = K_W3B;
                  slot      = opp_diag(normal_ff);
               end
            end
         end
         KIND_CONVEX_SOLID: begin
            if (diag) begin
               k[opp_straight(nx)] = K_W2A;
               k[opp_straight(ny)] = K_W2A;
               k[SLOT_C]           = K_W2B;
               slot                = opp_diag(normal_ff);
            end
         end
         default: begin
            k    = '0;
            slot = SLOT_C;
         end
      endcase
   end

   // A node with no valid result retires without issuing.
   assign last_idx = (idx_ff == cnt - 2'd1);
   assign issue    = en && hold_vld_ff && (cnt != 2'd0);
   assign retire   = en && hold_vld_ff && ((cnt == 2'd0) || last_idx);
   assign req_rdy  = en && (!hold_vld_ff || retire);
   assign accept   = req_vld && req_rdy;

   assign iss_ctl.valid = issue;
   assign iss_ctl.slot  = slot;
   assign iss_ctl.last  = last_idx;
   assign iss_coef      = k;
   assign iss_vals      = vals_ff;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      idx_in      = idx_ff;
      if (retire) begin
         hold_vld_in = 1'b0;
         idx_in      = 2'd0;
      end else if (issue) begin
         idx_in = idx_ff + 2'd1;
      end
      if (accept) begin
         hold_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         idx_ff      <= 2'd0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind;
         normal_ff <= normal;
         vals_ff   <= vals;
      end
   end

   a_idx_needs_node: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> hold_vld_ff)
      else $error("result index advanced without a held node");

   a_accept_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_vld && req_rdy && hold_vld_ff) |-> (cnt == 2'd0 || iss_ctl.last))
      else $error("new node taken before the held node issued its last result");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> (cnt == 2'd0 || idx_ff < cnt))
      else $error("result index ran past the node's result count");

endmodule
`default_nettype wire

### rtl/core/lbmbx_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbmbx_mac
// Weighted sum datapath: nine products, three partial sums, then the final
// sum with round to nearest and saturation.
// ----------------------------------------------------------------------------
module lbmbx_mac
   import lbmbx_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  ctl_type                          iss_ctl,
   input  coef_vec_type                     iss_coef,
   input  logic [NUM_SLOTS*VALUE_WIDTH-1:0] iss_vals,
   output ctl_type                          out_ctl,
   output logic [VALUE_WIDTH-1:0]           out_value
);

   localparam int PW  = VALUE_WIDTH + COEF_BITS + 1;
   localparam int SW  = PW + 4;
   localparam int SHW = SW - COEF_BITS;
   localparam logic signed [SW-1:0]  RND =
      {{(SW-COEF_BITS){1'b0}}, 1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [SHW-1:0] SAT_HI =
      {{(SHW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [SHW-1:0] SAT_LO =
      {{(SHW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

   ctl_type                s1_ctl_ff, s2_ctl_ff;
   logic signed [PW-1:0]   prod_ff [NUM_SLOTS];
   logic signed [SW-1:0]   grp_ff  [3];
   logic signed [SW-1:0]   total;
   logic signed [SHW-1:0]  shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= iss_ctl;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            prod_ff[i] <= $signed(iss_vals[i*VALUE_WIDTH +: VALUE_WIDTH])
                        * $signed({1'b0, iss_coef[i]});
         end
         for (int j = 0; j < 3; j++) begin
            grp_ff[j] <= SW'(prod_ff[3*j]) + SW'(prod_ff[3*j+1]) + SW'(prod_ff[3*j+2]);
         end
      end
   end

   // Adding half an LSB before the arithmetic shift rounds ties toward +inf.
   assign total   = grp_ff[0] + grp_ff[1] + grp_ff[2] + RND;
   assign shifted = total[SW-1:COEF_BITS];

   always_comb begin
      if (shifted > SAT_HI) begin
         out_value = SAT_HI[VALUE_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         out_value = SAT_LO[VALUE_WIDTH-1:0];
      end else begin
         out_value = shifted[VALUE_WIDTH-1:0];
      end
   end

   assign out_ctl = s2_ctl_ff;

   a_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_ctl_ff) && $stable(s2_ctl_ff))
      else $error("pipeline moved while the output was stalled");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      s1_ctl_ff.valid |-> s1_ctl_ff.slot <= SLOT_SE)
      else $error("issued result targets a slot outside the stencil");

endmodule
`default_nettype wire

### rtl/core/lbm_boundary_weighted_extrapolation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbm_boundary_weighted_extrapolation_core
// D2Q9 distance-weighted boundary extrapolation for one boundary node per
// word, producing none, one or three weighted-average results.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req_      in         req_tvalid/req_tready   tuser: kind, normal; tdata: 9 values
//  rsp_      out        rsp_tvalid/rsp_tready   tuser: slot; tdata: value; tlast
//
//  One result word leaves per cycle unless the output stalls. A node yields one
//  result, a concave-to-solid node three (one per result through the shared
//  multiply/add datapath), and one whose normal does not fit its kind none.
//  Results pass the input, product, partial-sum and output registers. Reset
//  clears all valid state; there is no clearing pass. A stalled output register
//  freezes the whole pipeline and the request side with it.
// ----------------------------------------------------------------------------
module lbm_boundary_weighted_extrapolation_core
   import lbmbx_pkg::*;
#(
   parameter  int VALUE_WIDTH = VALUE_WIDTH_DEF,
   localparam int REQ_DATA_W  = ((NUM_SLOTS * VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] kind, [6:3] normal
   input  logic [6:0]            req_tuser,
   // val_c, val_e, val_n, val_w, val_s, val_ne, val_nw, val_sw, val_se
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] slot
   output logic [3:0]            rsp_tuser,
   // value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                             en;
   ctl_type                          iss_ctl, out_ctl;
   coef_vec_type                     iss_coef;
   logic [NUM_SLOTS*VALUE_WIDTH-1:0] iss_vals;
   logic [VALUE_WIDTH-1:0]           out_value;

   logic                  rsp_vld_ff;
   logic [3:0]            rsp_slot_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   assign en = !rsp_vld_ff || rsp_tready;

   lbmbx_seq #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .req_vld  (req_tvalid),
      .req_rdy  (req_tready),
      .kind     (req_tuser[2:0]),
      .normal   (req_tuser[6:3]),
      .vals     (req_tdata[NUM_SLOTS*VALUE_WIDTH-1:0]),
      .iss_ctl  (iss_ctl),
      .iss_coef (iss_coef),
      .iss_vals (iss_vals)
   );

   lbmbx_mac #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .iss_ctl   (iss_ctl),
      .iss_coef  (iss_coef),
      .iss_vals  (iss_vals),
      .out_ctl   (out_ctl),
      .out_value (out_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= out_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_slot_ff <= out_ctl.slot;
         rsp_last_ff <= out_ctl.last;
         rsp_data_ff <= RSP_DATA_W'(out_value);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_slot_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

### dv/lbm_boundary_weighted_extrapolation_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_boundary_weighted_extrapolation_core_test
// Drives boundary nodes of every kind and normal into the extrapolation core.
// The test predicts each weighted, rounded and saturated result, and checks
// slot, value and last flag in order while both sides of the core idle and
// stall at random.
// ----------------------------------------------------------------------------
module lbm_boundary_weighted_extrapolation_core_test;
   import lbmbx_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_NODES = 133;

   // Kind and normal codes that the core must ignore.
   localparam logic [2:0] KIND_SPARE_LO       = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI       = 3'd7;
   localparam logic [3:0] NORMAL_PAST_CORNERS = 4'd9;
   localparam logic [3:0] NORMAL_MAX          = 4'd15;

   // Normalized distance weights in unsigned Q0.18: axial and diagonal share.
   localparam logic [17:0] W_WALL_AX = 18'd108584;
   localparam logic [17:0] W_WALL_DG = 18'd76780;
   localparam logic [17:0] W_CNR_AX  = 18'd96835;
   localparam logic [17:0] W_CNR_DG  = 18'd68473;
   localparam logic [17:0] W_KNT_AX  = 18'd115741;
   localparam logic [17:0] W_KNT_DG  = 18'd73201;
   localparam logic [17:0] W_SOL_AX  = 18'd153560;
   localparam logic [17:0] W_SOL_DG  = 18'd108584;
   localparam logic [17:0] W_CVX_AX  = 18'd42825;
   localparam logic [17:0] W_CVX_DG  = 18'd30282;

   typedef logic [8:0][31:0] stencil_type;
   typedef logic [8:0][17:0] weight_set_type;

   typedef struct {
      logic [3:0]  slot;
      logic [31:0] value;
      logic        last;
      int          node;
   } extrapolated_type;

   class boundary_ledger;
      extrapolated_type expected_q[$];
      int mismatches;
      int nodes;

      function new();
         mismatches = 0;
         nodes = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      static function logic [3:0] across_straight(logic [3:0] s);
         case (s)
            SLOT_E:  return SLOT_W;
            SLOT_N:  return SLOT_S;
            SLOT_W:  return SLOT_E;
            SLOT_S:  return SLOT_N;
            default: return SLOT_C;
         endcase
      endfunction

      static function logic [3:0] across_diagonal(logic [3:0] d);
         case (d)
            SLOT_NE: return SLOT_SW;
            SLOT_NW: return SLOT_SE;
            SLOT_SW: return SLOT_NE;
            SLOT_SE: return SLOT_NW;
            default: return SLOT_C;
         endcase
      endfunction

      // Sum of products, rounded half up at the Q0.18 point, then clamped.
      static function logic [31:0] weighted_average(stencil_type s, weight_set_type w);
         longint acc;
         longint q;
         acc = 0;
         for (int i = 0; i < 9; i++)
            acc += longint'($signed(s[i])) * longint'(w[i]);
         acc += longint'(1) << 17;
         q = acc >>> 18;
         if (q > longint'(32'sh7fff_ffff))
            return 32'h7fff_ffff;
         else if (q < -longint'(64'sd2147483648))
            return 32'h8000_0000;
         else
            return q[31:0];
      endfunction

      function void add_result(logic [3:0] slot, stencil_type s, weight_set_type w);
         extrapolated_type r;
         r.slot  = slot;
         r.value = weighted_average(s, w);
         r.last  = 1'b0;
         r.node  = nodes;
         expected_q.push_back(r);
      endfunction

      function int note_node(logic [2:0] kind, logic [3:0] nrm, stencil_type s);
         weight_set_type w;
         logic [3:0] x, y, side;
         bit straight, corner;
         int first;
         first = expected_q.size();
         w = '0;
         straight = nrm >= SLOT_E && nrm <= SLOT_S;
         corner = nrm >= SLOT_NE && nrm <= SLOT_SE;
         x = (nrm == SLOT_NE || nrm == SLOT_SE) ? SLOT_E : SLOT_W;
         y = (nrm == SLOT_NE || nrm == SLOT_NW) ? SLOT_N : SLOT_S;
         case (kind)
            KIND_ON_WALL: if (straight) begin
               // The normal link plus the two diagonals that flank it.
               side = ((nrm + 4'd2) & 4'd3) + 4'd5;
               w[nrm] = W_WALL_AX;
               w[nrm + 4'd4] = W_WALL_DG;
               w[side] = W_WALL_DG;
               add_result(SLOT_C, s, w);
            end
            KIND_CONCAVE: if (corner) begin
               w[x] = W_CNR_AX;
               w[y] = W_CNR_AX;
               w[nrm] = W_CNR_DG;
               add_result(SLOT_C, s, w);
            end
            KIND_CONVEX: if (corner) begin
               for (int i = SLOT_E; i <= SLOT_S; i++) w[i] = W_CVX_AX;
               for (int i = SLOT_NE; i <= SLOT_SE; i++) w[i] = W_CVX_DG;
               w[across_diagonal(nrm)] = '0;
               add_result(SLOT_C, s, w);
            end
            KIND_WALL_SOLID: if (straight) begin
               side = (nrm & 4'd3) + 4'd1;
               w[SLOT_C] = W_WALL_AX;
               w[side] = W_WALL_DG;
               w[across_straight(side)] = W_WALL_DG;
               add_result(across_straight(nrm), s, w);
            end
            KIND_CONCAVE_SOLID: if (corner) begin
               w[SLOT_C] = W_SOL_AX;
               w[y] = W_SOL_DG;
               add_result(across_straight(x), s, w);
               w[y] = '0;
               w[x] = W_SOL_DG;
               add_result(across_straight(y), s, w);
               w[SLOT_C] = W_KNT_AX;
               w[x] = W_KNT_DG;
               w[y] = W_KNT_DG;
               add_result(across_diagonal(nrm), s, w);
            end
            KIND_CONVEX_SOLID: if (corner) begin
               w[across_straight(x)] = W_CNR_AX;
               w[across_straight(y)] = W_CNR_AX;
               w[SLOT_C] = W_CNR_DG;
               add_result(across_diagonal(nrm), s, w);
            end
            default: ;
         endcase
         if (expected_q.size() > first)
            expected_q[expected_q.size() - 1].last = 1'b1;
         nodes++;
         return expected_q.size() - first;
      endfunction

      function void check_result(logic [3:0] slot, logic [31:0] value, logic last);
         extrapolated_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: slot %0d value %h last %b", slot, value, last);
            return;
         end
         e = expected_q.pop_front();
         if (slot !== e.slot || value !== e.value || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"node %0d: expected slot %0d value %h last %b, ",
                         "got slot %0d value %h last %b"},
                        e.node, e.slot, e.value, e.last, slot, value, last);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [2:0] kind, [6:3] normal
   logic [6:0]   req_tuser = '0;
   // val_c, val_e, val_n, val_w, val_s, val_ne, val_nw, val_sw, val_se
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [3:0] slot
   logic [3:0]   rsp_tuser;
   // value
   logic [31:0]  rsp_tdata;
   logic         rsp_tlast;

   boundary_ledger ledger = new();
   bit draining = 1'b0;
   int cycle_count = 0;
   int ready_mode = 0;
   int mode_left = 0;
   int stall_left = 0;

   lbm_boundary_weighted_extrapolation_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // The receiver switches between free flow, coin flips, sparse acceptance
   // and long stalls, so that back pressure lands on every pipeline phase.
   always @(negedge clock) begin
      if (draining) begin
         rsp_tready <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 4) == 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_tready <= 1'b0;
               end else if ($urandom_range(0, 7) == 0) begin
                  stall_left = $urandom_range(5, 30);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         ledger.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic stencil_type uniform_stencil(logic [31:0] v);
      stencil_type s;
      for (int i = 0; i < 9; i++) s[i] = v;
      return s;
   endfunction

   function automatic stencil_type random_stencil();
      stencil_type s;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         case (mode)
            5, 6: s[i] = $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
            7: begin
               case ($urandom_range(0, 4))
                  0: s[i] = 32'h7fff_ffff;
                  1: s[i] = 32'h8000_0000;
                  2: s[i] = 32'h0000_0000;
                  3: s[i] = 32'hffff_ffff;
                  default: s[i] = 32'h0000_0001;
               endcase
            end
            8: s[i] = 32'h7fff_ffff - $urandom_range(0, 255);
            9: s[i] = 32'h8000_0000 + $urandom_range(0, 255);
            default: s[i] = $urandom;
         endcase
      end
      return s;
   endfunction

   task automatic send_node(input logic [2:0] kind, input logic [3:0] nrm,
                            input stencil_type s, output int made);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= {nrm, kind};
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      made = ledger.note_node(kind, nrm, s);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_all_results();
      idle_gap(1);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   initial begin
      stencil_type vals;
      logic [2:0] kind;
      logic [3:0] nrm;
      int made;
      int sent;
      int burst;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every normal under two fitting kinds.
      for (int n = SLOT_E; n <= SLOT_SE; n++) begin
         nrm = 4'(n);
         for (int j = 0; j < 2; j++) begin
            if (nrm <= SLOT_S)
               kind = j ? KIND_WALL_SOLID : KIND_ON_WALL;
            else if (nrm == SLOT_NE || nrm == SLOT_SW)
               kind = j ? KIND_CONCAVE_SOLID : KIND_CONCAVE;
            else
               kind = j ? KIND_CONVEX_SOLID : KIND_CONVEX;
            send_node(kind, nrm, random_stencil(), made);
            idle_gap($urandom_range(0, 2));
         end
      end

      // The convex corner weights sum just above one, so full-scale inputs clamp.
      send_node(KIND_CONVEX, SLOT_NE, uniform_stencil(32'h7fff_ffff), made);
      send_node(KIND_CONVEX, SLOT_SW, uniform_stencil(32'h8000_0000), made);
      send_node(KIND_CONCAVE_SOLID, SLOT_NW, uniform_stencil('0), made);
      for (int i = 0; i < 9; i++) vals[i] = i[0] ? 32'h7fff_ffff : 32'h8000_0000;
      send_node(KIND_WALL_SOLID, SLOT_N, vals, made);
      // Unused kinds, out-of-range normals and normals that do not fit the kind.
      send_node(KIND_SPARE_LO, SLOT_E, random_stencil(), made);
      send_node(KIND_SPARE_HI, SLOT_SE, random_stencil(), made);
      send_node(KIND_ON_WALL, SLOT_NE, random_stencil(), made);
      send_node(KIND_CONCAVE, SLOT_N, random_stencil(), made);
      send_node(KIND_CONVEX_SOLID, NORMAL_MAX, random_stencil(), made);
      send_node(KIND_WALL_SOLID, SLOT_C, random_stencil(), made);
      send_node(KIND_CONCAVE_SOLID, NORMAL_PAST_CORNERS, random_stencil(), made);
      wait_all_results();

      sent = 0;
      while (sent < RANDOM_NODES) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < RANDOM_NODES; b++) begin
            if ($urandom_range(0, 6) == 0) begin
               kind = 3'($urandom_range(0, 7));
               nrm = 4'($urandom_range(0, 15));
            end else begin
               kind = 3'($urandom_range(KIND_ON_WALL, KIND_CONVEX_SOLID));
               if (kind == KIND_ON_WALL || kind == KIND_WALL_SOLID)
                  nrm = 4'($urandom_range(SLOT_E, SLOT_S));
               else
                  nrm = 4'($urandom_range(SLOT_NE, SLOT_SE));
            end
            send_node(kind, nrm, random_stencil(), made);
            sent++;
         end
         if ($urandom_range(0, 9) == 0)
            wait_all_results();
         else if ($urandom_range(0, 2) == 0)
            idle_gap(0);
         else
            idle_gap($urandom_range(1, 12));
      end

      wait_all_results();
      draining = 1'b1;
      repeat (12) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
